>>> sv/rrts_pkg.sv
package rrts_pkg;

  localparam int DEFAULT_MAX_SLOTS = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [2:0] state_t;
  typedef logic [2:0] op_t;

  localparam state_t ST_INVALID  = 3'd0;
  localparam state_t ST_CREATED  = 3'd1;
  localparam state_t ST_EXEC     = 3'd2;
  localparam state_t ST_PAUSED   = 3'd3;
  localparam state_t ST_RETURNED = 3'd4;

  localparam op_t OP_YIELD    = 3'd0;
  localparam op_t OP_CREATE   = 3'd1;
  localparam op_t OP_PAUSE    = 3'd2;
  localparam op_t OP_RESUME   = 3'd3;
  localparam op_t OP_RESTART  = 3'd4;
  localparam op_t OP_QUERY    = 3'd5;
  localparam op_t OP_RETURNED = 3'd6;
  localparam op_t OP_NOP      = 3'd7;

  // A command as it waits in the queue between the front and back ends.
  typedef struct packed {
    op_t        op;
    logic       slot_op;
    logic [2:0] idx;
  } cmd_t;

endpackage

>>> sv/rrts_front.sv
module rrts_front import rrts_pkg::*; (
  input  logic       start,
  input  logic [2:0] in_operation,
  input  logic [2:0] in_task_index,
  input  logic       q_full,
  output logic       busy,
  output logic       push,
  output cmd_t       push_cmd
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_cmd.op      = in_operation;
    push_cmd.idx     = in_task_index;
    push_cmd.slot_op = in_operation inside {[OP_PAUSE:OP_RETURNED]};
    // The no-operation command has its task index cleared.
    if (in_operation == OP_NOP) begin
      push_cmd.op  = OP_NOP;
      push_cmd.idx = '0;
    end
  end

endmodule

>>> sv/rrts_queue.sv
module rrts_queue import rrts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/rrts_exec.sv
module rrts_exec import rrts_pkg::*; #(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_strobe,
  output logic [2:0] out_result_state,
  output logic [2:0] out_prev_task,
  output logic [2:0] out_next_task,
  output logic       out_switched
);

  localparam int CW   = $clog2(MAX_SLOTS);
  localparam int CMPW = (CW > 3) ? CW : 3;

  state_t               st_r [MAX_SLOTS];
  state_t               st_nxt [MAX_SLOTS];
  logic [CW-1:0]        count_r, count_nxt;
  logic [MAX_SLOTS-1:0] round_r, round_nxt;
  logic [MAX_SLOTS-1:0] en_r, en_nxt;

  logic                 strobe_r;
  state_t               rs_r, rs_nxt;
  logic [2:0]           prev_r, prev_nxt;
  logic [2:0]           next_r, next_nxt;
  logic                 sw_r, sw_nxt;

  logic [MAX_SLOTS-1:0] rest;
  logic [CW-1:0]        tail, head_raw, head;
  logic [CW:0]          slot_wide;
  logic [CW-1:0]        slot;
  logic [CMPW-1:0]      idx_ext;
  logic                 do_yield, do_create, do_slot;
  logic [MAX_SLOTS-1:0] tail_sel, head_sel, idx_sel, new_sel;
  state_t               s_tail, s_head, s_idx, nl, nn;

  function automatic logic [CW-1:0] lowest(input logic [MAX_SLOTS-1:0] m);
    logic [CW-1:0] r;
    r = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) r = CW'(i);
    end
    return r;
  endfunction

  assign pop = !q_empty;

  always_comb begin
    rest      = round_r & (round_r - MAX_SLOTS'(1));
    tail      = lowest(round_r);
    head_raw  = (|rest) ? lowest(rest) : '0;
    // A next slot beyond the created tasks falls back to the main context.
    head      = (head_raw > count_r) ? '0 : head_raw;
    slot_wide = {1'b0, count_r} + (CW+1)'(1);
    slot      = slot_wide[CW-1:0];
    idx_ext   = CMPW'(q_cmd.idx);

    do_yield  = pop && (q_cmd.op == OP_YIELD) && (count_r != '0) && (|round_r);
    do_create = pop && (q_cmd.op == OP_CREATE) && (slot_wide < (CW+1)'(MAX_SLOTS));
    do_slot   = pop && q_cmd.slot_op && (idx_ext <= CMPW'(count_r));

    s_tail = '0;
    s_head = '0;
    s_idx  = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      tail_sel[i] = (tail == CW'(i));
      head_sel[i] = (head == CW'(i));
      idx_sel[i]  = (idx_ext == CMPW'(i));
      new_sel[i]  = (slot == CW'(i));
      s_tail = s_tail | (tail_sel[i] ? st_r[i] : ST_INVALID);
      s_head = s_head | (head_sel[i] ? st_r[i] : ST_INVALID);
      s_idx  = s_idx  | (idx_sel[i]  ? st_r[i] : ST_INVALID);
    end

    nl = (s_tail == ST_PAUSED || s_tail == ST_RETURNED) ? s_tail : ST_CREATED;
    nn = (s_head == ST_PAUSED || s_head == ST_RETURNED) ? s_head : ST_EXEC;

    count_nxt = count_r;
    round_nxt = round_r;
    en_nxt    = en_r;
    rs_nxt    = ST_INVALID;
    prev_nxt  = '0;
    next_nxt  = '0;
    sw_nxt    = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      st_nxt[i] = st_r[i];
    end

    if (do_yield) begin
      // When outgoing and incoming are the same slot, the incoming rule wins.
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (head_sel[i]) begin
          st_nxt[i] = nn;
        end else if (tail_sel[i]) begin
          st_nxt[i] = nl;
        end
      end
      round_nxt = (|rest) ? rest : en_r;
      rs_nxt    = nn;
      prev_nxt  = 3'(tail);
      next_nxt  = 3'(head);
      sw_nxt    = 1'b1;
    end

    if (do_create) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (new_sel[i]) st_nxt[i] = ST_CREATED;
      end
      round_nxt = round_r | new_sel;
      en_nxt    = round_r | new_sel;
      count_nxt = slot;
      rs_nxt    = ST_CREATED;
      next_nxt  = 3'(slot);
    end

    if (do_slot) begin
      case (q_cmd.op)
        OP_PAUSE: begin
          if (s_idx != ST_PAUSED) begin
            en_nxt = en_r & ~idx_sel;
          end
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (idx_sel[i]) st_nxt[i] = ST_PAUSED;
          end
          rs_nxt = ST_PAUSED;
        end
        OP_RESUME: begin
          if (s_idx == ST_PAUSED) begin
            en_nxt = en_r | idx_sel;
            for (int i = 0; i < MAX_SLOTS; i++) begin
              if (idx_sel[i]) st_nxt[i] = ST_CREATED;
            end
            rs_nxt = ST_CREATED;
          end else begin
            rs_nxt = s_idx;
          end
        end
        OP_RESTART: begin
          if (s_idx == ST_RETURNED) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
              if (idx_sel[i]) st_nxt[i] = ST_CREATED;
            end
            rs_nxt = ST_CREATED;
          end
        end
        OP_QUERY: begin
          rs_nxt = s_idx;
        end
        OP_RETURNED: begin
          for (int i = 0; i < MAX_SLOTS; i++) begin
            if (idx_sel[i]) st_nxt[i] = ST_RETURNED;
          end
          rs_nxt = ST_RETURNED;
        end
        default: begin
          rs_nxt = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        st_r[i] <= (i == 0) ? ST_CREATED : ST_INVALID;
      end
      count_r  <= '0;
      round_r  <= MAX_SLOTS'(1);
      en_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        st_r[i] <= st_nxt[i];
      end
      count_r  <= count_nxt;
      round_r  <= round_nxt;
      en_r     <= en_nxt;
      strobe_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rs_r   <= rs_nxt;
      prev_r <= prev_nxt;
      next_r <= next_nxt;
      sw_r   <= sw_nxt;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_result_state = rs_r;
  assign out_prev_task    = prev_r;
  assign out_next_task    = next_r;
  assign out_switched     = sw_r;

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> strobe_r)
    else $error("popped command produced no result");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> !strobe_r)
    else $error("result without a popped command");

  a_main_never_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    st_r[0] != ST_INVALID)
    else $error("main context slot became invalid");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CMPW+1)'(count_r) < (CMPW+1)'(MAX_SLOTS))
    else $error("task count beyond slot range");

endmodule

>>> sv/round_robin_task_scheduler.sv
// Cooperative round-robin task scheduler (state bookkeeping only). A command
// is accepted on a rising edge with start high and busy low; its single
// result is driven with out_strobe high for one cycle, once the command has
// passed through the queue storage and then the result registers. Results
// leave in the order commands came in. A front end decodes commands into a
// two-entry queue; the back end drains one command per cycle, so the
// sustained rate is one command per cycle and the queue never holds more
// than one item, which keeps busy low. The receiver cannot stall and must
// take each result in the cycle it is strobed.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [2:0] in_task_index,
  output logic       out_strobe,
  output logic [2:0] out_result_state,
  output logic [2:0] out_prev_task,
  output logic [2:0] out_next_task,
  output logic       out_switched
);

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, pop_cmd;

  rrts_front u_front (
    .start         (start),
    .in_operation  (in_operation),
    .in_task_index (in_task_index),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  rrts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  rrts_exec #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_exec (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (pop_cmd),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_result_state (out_result_state),
    .out_prev_task    (out_prev_task),
    .out_next_task    (out_next_task),
    .out_switched     (out_switched)
  );

endmodule

>>> sim/round_robin_task_scheduler_tb.sv
module round_robin_task_scheduler_tb;
  import rrts_pkg::*;

  localparam int SLOTS = DEFAULT_MAX_SLOTS;
  localparam int RANDOM_ITEMS = 310;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    state_t     result_state;
    logic [2:0] prev_task;
    logic [2:0] next_task;
    logic       switched;
  } sched_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_operation;
  logic [2:0] in_task_index;
  logic       out_strobe;
  logic [2:0] out_result_state;
  logic [2:0] out_prev_task;
  logic [2:0] out_next_task;
  logic       out_switched;

  // Scheduler state as predicted from the accepted commands.
  state_t           slot_state [SLOTS];
  int               created_count;
  logic [SLOTS-1:0] round_bits;
  logic [SLOTS-1:0] enable_bits;

  sched_result_t pending_results [$];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            idle_pct = 0;

  round_robin_task_scheduler u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_task_index    (in_task_index),
    .out_strobe       (out_strobe),
    .out_result_state (out_result_state),
    .out_prev_task    (out_prev_task),
    .out_next_task    (out_next_task),
    .out_switched     (out_switched)
  );

  always #1 clk = ~clk;

  function automatic int lowest_set(logic [SLOTS-1:0] m);
    for (int i = 0; i < SLOTS; i++) begin
      if (m[i]) return i;
    end
    return 0;
  endfunction

  function automatic sched_result_t apply_command(op_t op, logic [2:0] idx);
    sched_result_t    r;
    logic [SLOTS-1:0] rest;
    int               tail;
    int               head;
    int               slot;
    int               i;
    state_t           ls;
    state_t           ns;
    state_t           nl;
    state_t           nn;
    r = '0;
    i = idx;
    case (op)
      OP_YIELD: begin
        if (created_count != 0 && round_bits != '0) begin
          tail = lowest_set(round_bits);
          rest = round_bits & (round_bits - 1'b1);
          head = (rest != '0) ? lowest_set(rest) : 0;
          if (head > created_count) head = 0;
          ls = slot_state[tail];
          ns = slot_state[head];
          nl = (ls == ST_PAUSED || ls == ST_RETURNED) ? ls : ST_CREATED;
          nn = (ns == ST_PAUSED || ns == ST_RETURNED) ? ns : ST_EXEC;
          // The incoming update is applied last so it wins on a self switch.
          slot_state[tail] = nl;
          slot_state[head] = nn;
          round_bits = (rest == '0) ? enable_bits : rest;
          r.result_state = nn;
          r.prev_task = tail[2:0];
          r.next_task = head[2:0];
          r.switched = 1'b1;
        end
      end
      OP_CREATE: begin
        slot = created_count + 1;
        if (slot < SLOTS) begin
          slot_state[slot] = ST_CREATED;
          round_bits[slot] = 1'b1;
          enable_bits = round_bits;
          created_count = slot;
          r.result_state = ST_CREATED;
          r.next_task = slot[2:0];
        end
      end
      OP_NOP: ;
      default: begin
        if (i <= created_count && i < SLOTS) begin
          case (op)
            OP_PAUSE: begin
              if (slot_state[i] != ST_PAUSED) begin
                slot_state[i] = ST_PAUSED;
                enable_bits[i] = 1'b0;
              end
              r.result_state = ST_PAUSED;
            end
            OP_RESUME: begin
              if (slot_state[i] == ST_PAUSED) begin
                slot_state[i] = ST_CREATED;
                enable_bits[i] = 1'b1;
                r.result_state = ST_CREATED;
              end else begin
                r.result_state = slot_state[i];
              end
            end
            OP_RESTART: begin
              if (slot_state[i] == ST_RETURNED) begin
                slot_state[i] = ST_CREATED;
                r.result_state = ST_CREATED;
              end else begin
                r.result_state = ST_INVALID;
              end
            end
            OP_QUERY: r.result_state = slot_state[i];
            default: begin
              slot_state[i] = ST_RETURNED;
              r.result_state = ST_RETURNED;
            end
          endcase
        end
      end
    endcase
    return r;
  endfunction

  task automatic issue_command(op_t op, logic [2:0] idx);
    start <= 1'b1;
    in_operation <= op;
    in_task_index <= idx;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(op, idx));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_operation <= 3'($urandom);
      in_task_index <= 3'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Before any task exists and with indexes past the last created slot.
  task automatic test_no_tasks();
    issue_command(OP_YIELD, 3'd0);
    issue_command(OP_QUERY, 3'd0);
    issue_command(OP_QUERY, 3'd3);
    issue_command(OP_PAUSE, 3'd2);
    issue_command(OP_NOP, 3'd7);
  endtask

  task automatic test_create_yield();
    issue_command(OP_CREATE, 3'd0);
    issue_command(OP_YIELD, 3'd0);
    issue_command(OP_YIELD, 3'd0);
  endtask

  // Pausing every task stops the round from refilling; once it drains, yields switch nothing.
  task automatic test_empty_round();
    issue_command(OP_PAUSE, 3'd0);
    issue_command(OP_PAUSE, 3'd1);
    issue_command(OP_YIELD, 3'd0);
    issue_command(OP_YIELD, 3'd0);
    issue_command(OP_YIELD, 3'd0);
    issue_command(OP_RESUME, 3'd1);
    issue_command(OP_RESUME, 3'd0);
    issue_command(OP_RESUME, 3'd1);
  endtask

  task automatic test_slot_ops();
    issue_command(OP_RETURNED, 3'd1);
    issue_command(OP_RESTART, 3'd1);
    issue_command(OP_RESTART, 3'd0);
    issue_command(OP_QUERY, 3'd1);
    issue_command(OP_CREATE, 3'd7);
  endtask

  task automatic test_random(int pct);
    int   sel;
    op_t  op;
    logic [2:0] idx;
    idle_pct = pct;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(99);
      // Creates are rare so that the task count climbs slowly through the run.
      if (sel < 1)       op = OP_CREATE;
      else if (sel < 40) op = OP_YIELD;
      else if (sel < 50) op = OP_PAUSE;
      else if (sel < 60) op = OP_RESUME;
      else if (sel < 67) op = OP_RESTART;
      else if (sel < 76) op = OP_QUERY;
      else if (sel < 86) op = OP_RETURNED;
      else if (sel < 88) op = OP_NOP;
      else               op = 3'($urandom);
      if (op == OP_CREATE && $urandom_range(3) != 0) op = OP_YIELD;
      if ($urandom_range(99) < 85) idx = 3'($urandom_range(created_count));
      else idx = 3'($urandom);
      issue_command(op, idx);
    end
  endtask

  task automatic test_full();
    idle_pct = 0;
    while (created_count < SLOTS - 1) issue_command(OP_CREATE, 3'd0);
    issue_command(OP_CREATE, 3'd0);
    issue_command(OP_CREATE, 3'd5);
    issue_command(OP_QUERY, 3'd7);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    sched_result_t exp_r;
    sched_result_t got_r;
    if (rst_n && out_strobe) begin
      got_r = '{out_result_state, out_prev_task, out_next_task, out_switched};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got_r);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.result_state !== exp_r.result_state) begin
          $display("%0t: result_state expected %0d actual %0d", $time,
                   exp_r.result_state, got_r.result_state);
          fail_count++;
        end
        if (got_r.prev_task !== exp_r.prev_task) begin
          $display("%0t: prev_task expected %0d actual %0d", $time,
                   exp_r.prev_task, got_r.prev_task);
          fail_count++;
        end
        if (got_r.next_task !== exp_r.next_task) begin
          $display("%0t: next_task expected %0d actual %0d", $time,
                   exp_r.next_task, got_r.next_task);
          fail_count++;
        end
        if (got_r.switched !== exp_r.switched) begin
          $display("%0t: switched expected %0d actual %0d", $time,
                   exp_r.switched, got_r.switched);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_NOP;
    in_task_index = 3'd0;
    for (int i = 0; i < SLOTS; i++) slot_state[i] = ST_INVALID;
    slot_state[0] = ST_CREATED;
    created_count = 0;
    round_bits = 1;
    enable_bits = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_tasks();
    test_create_yield();
    test_empty_round();
    test_slot_ops();
    test_random(0);
    test_random(86);
    test_random(25);
    test_full();
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
